>>> rtl/core/block_bump_allocator_unit_assert.svh
// Assertion macros used by the bump allocator top level.
`ifndef BLOCK_BUMP_ALLOCATOR_UNIT_ASSERT_SVH
`define BLOCK_BUMP_ALLOCATOR_UNIT_ASSERT_SVH

// Check a property on clk_i, disabled while reset is asserted.
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on clk_i, also during reset.
`define BBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/bba_pkg.sv
// Types, constants and register codes of the bump allocator.
package bba_pkg;

  // Default parameter values.
  localparam int BBA_BLOCK_BYTES = 16777216;
  localparam int BBA_CHUNK_ALIGN = 16;
  localparam int BBA_MAX_BLOCKS  = 16;

  // Field widths.
  localparam int SIZE_W = 32;
  localparam int OFS_W  = 25;
  localparam int SUM_W  = 29;
  localparam int BLK_W  = 4;
  localparam int LIM_W  = 5;
  localparam int CFG_W  = 5;
  localparam int IDX_W  = 1;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_BLOCK_LIMIT = 1'd0;
  localparam logic [IDX_W-1:0] REG_ALLOW_HUGE  = 1'd1;

  // Opcodes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_HUGE     = 2'd1,
    ST_HUGE_ERR = 2'd2,
    ST_NO_BLOCK = 2'd3
  } status_e;

  typedef struct packed {
    logic              opcode;
    logic [SIZE_W-1:0] req_size;
    logic [BLK_W-1:0]  free_block;
    logic [OFS_W-1:0]  free_offset;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [BLK_W-1:0]  out_block;
    logic [OFS_W-1:0]  out_offset;
    logic [SUM_W-1:0]  total_used;
  } rsp_t;

  // Request beat as it travels down the row of block cells.
  typedef struct packed {
    logic             valid;
    logic             opcode;
    status_e          status;   // nonzero: oversize, cells leave it alone
    logic [OFS_W-1:0] size;
    logic [OFS_W-1:0] chunk;
    logic [BLK_W-1:0] fblk;
    logic [OFS_W-1:0] fofs;
    logic             found;    // a cell took the allocation or the free
    logic             opened;   // the allocation opened a new block
    logic [BLK_W-1:0] hit;
    logic [OFS_W-1:0] hit_ofs;
    logic [OFS_W-1:0] dec;
  } tok_t;

endpackage

>>> rtl/core/bba_cell.sv
// One block cell: bump offset and used count of one block, one pipeline hop.
module bba_cell
  import bba_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int MAX_BLOCKS  = BBA_MAX_BLOCKS,
  parameter int BLOCK_BYTES = BBA_BLOCK_BYTES,
  parameter int CNT_W       = $clog2(MAX_BLOCKS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tok_t             tok_i,
  input  logic [CNT_W-1:0] open_i,
  input  logic [CNT_W-1:0] limit_i,
  output tok_t             tok_o
);

  localparam logic [CNT_W-1:0] ME = CNT_W'(IDX);

  logic [OFS_W-1:0] bump_q, bump_d;
  logic [OFS_W-1:0] used_q, used_d;
  tok_t             tok_q, tok_d;

  logic             active;
  logic             fits;
  logic             roll;
  logic [OFS_W-1:0] dec;
  logic [OFS_W-1:0] used_n;
  logic [OFS_W:0]   end_ofs;

  assign active  = tok_i.valid && (tok_i.status == ST_OK) && !tok_i.found;
  assign fits    = ({1'b0, bump_q} + {1'b0, tok_i.size}) <= (OFS_W + 1)'(BLOCK_BYTES);
  assign dec     = (tok_i.chunk > used_q) ? used_q : tok_i.chunk;
  assign used_n  = used_q - dec;
  assign end_ofs = {1'b0, tok_i.fofs} + {1'b0, tok_i.chunk};
  assign roll    = ({1'b0, bump_q} == end_ofs);

  // Claim the beat for this block and update its state.
  always_comb begin
    tok_d  = tok_i;
    bump_d = bump_q;
    used_d = used_q;
    if (active && tok_i.opcode == OP_ALLOC) begin
      if (ME < open_i) begin
        if (fits) begin
          tok_d.found   = 1'b1;
          tok_d.hit     = BLK_W'(IDX);
          tok_d.hit_ofs = bump_q;
          bump_d        = bump_q + tok_i.chunk;
          used_d        = used_q + tok_i.chunk;
        end
      end else if (ME == open_i && open_i < limit_i) begin
        tok_d.found   = 1'b1;
        tok_d.opened  = 1'b1;
        tok_d.hit     = BLK_W'(IDX);
        tok_d.hit_ofs = '0;
        bump_d        = tok_i.chunk;
        used_d        = tok_i.chunk;
      end
    end else if (active && tok_i.opcode == OP_FREE) begin
      if ((32'(tok_i.fblk) == IDX) && (ME < open_i)) begin
        tok_d.found = 1'b1;
        tok_d.dec   = dec;
        used_d      = used_n;
        if (used_n == '0) begin
          bump_d = '0;
        end else if (roll) begin
          bump_d = bump_q - tok_i.chunk;
        end
      end
    end
  end

  // Hold block state and pass the beat on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bump_q <= '0;
      used_q <= '0;
      tok_q  <= '0;
    end else begin
      bump_q <= bump_d;
      used_q <= used_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> rtl/core/block_bump_allocator_unit.sv
// Top level of the first-fit multi-block bump allocator.
//
// Requests arrive on in_data_i with in_valid_i/in_stall_o; a beat is taken
// when valid is high and stall is low. Each request gives one response beat
// on out_data_o with out_valid_o/out_stall_i. Configuration registers
// (block_limit, allow_huge) are written through cfg_we_i/cfg_idx_i/cfg_data_i
// by the user, who must do so only while the block is idle (not enforced).
// A request enters an entry register, then walks the row of MAX_BLOCKS block
// cells, one cell per cycle, each cell checking and updating its own block.
// It then passes a result stage and the output register. One request walks
// the row at a time: a new request is taken only once the previous response
// has moved from the result stage into the output register.
// The output register holds a finished response while the receiver stalls,
// and the next request may already be walking the row; a second finished
// response waits in the result stage and holds off new requests.
// Reset clears all block state, the block count, the byte total and the
// configuration (no block limit, oversize reported as huge).
module block_bump_allocator_unit
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS  = BBA_MAX_BLOCKS,
  parameter int BLOCK_BYTES = BBA_BLOCK_BYTES,
  parameter int CHUNK_ALIGN = BBA_CHUNK_ALIGN
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsp_t             out_data_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  // Configuration.
  logic [LIM_W-1:0] limit_q;
  logic             huge_ok_q;
  logic [CNT_W-1:0] limit_eff;

  // Allocator totals.
  logic [CNT_W-1:0] open_q;
  logic [SUM_W-1:0] sum_q;

  logic             busy_q;
  logic             in_acc;
  tok_t             chain [MAX_BLOCKS+1];
  logic [MAX_BLOCKS:0] chain_vld;
  tok_t             entry_d;
  tok_t             entry_q;
  logic [OFS_W+1:0] round_up;
  tok_t             ex;

  rsp_t             pend_q, pend_d;
  logic             pend_vld_q;
  rsp_t             out_q;
  logic             out_vld_q;
  logic             out_free;
  logic [SUM_W-1:0] sum_d;

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;
  assign out_free   = !out_vld_q || !out_stall_i;

  assign limit_eff = (limit_q == '0 || 32'(limit_q) > MAX_BLOCKS) ?
                     CNT_W'(MAX_BLOCKS) : CNT_W'(limit_q);

  // Write configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= '0;
      huge_ok_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BLOCK_LIMIT: limit_q   <= cfg_data_i[LIM_W-1:0];
        REG_ALLOW_HUGE:  huge_ok_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Build the entry beat: oversize check and chunk rounding.
  assign round_up = {2'b00, in_data_i.req_size[OFS_W-1:0]} + (OFS_W + 2)'(CHUNK_ALIGN - 1);

  always_comb begin
    entry_d         = '0;
    entry_d.valid   = in_acc;
    entry_d.opcode  = in_data_i.opcode;
    entry_d.size    = in_data_i.req_size[OFS_W-1:0];
    entry_d.chunk   = OFS_W'((round_up / CHUNK_ALIGN) * CHUNK_ALIGN);
    entry_d.fblk    = in_data_i.free_block;
    entry_d.fofs    = in_data_i.free_offset;
    if (in_data_i.req_size > SIZE_W'(BLOCK_BYTES)) begin
      entry_d.status = huge_ok_q ? ST_HUGE : ST_HUGE_ERR;
    end else begin
      entry_d.status = ST_OK;
    end
  end

  // Hold the entry beat for the first cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign chain[0] = entry_q;

  // Row of block cells.
  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    bba_cell #(
      .IDX         (g),
      .MAX_BLOCKS  (MAX_BLOCKS),
      .BLOCK_BYTES (BLOCK_BYTES),
      .CNT_W       (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (chain[g]),
      .open_i  (open_q),
      .limit_i (limit_eff),
      .tok_o   (chain[g+1])
    );
  end

  for (genvar g = 0; g <= MAX_BLOCKS; g++) begin : g_vld
    assign chain_vld[g] = chain[g].valid;
  end

  // Finish the beat leaving the row.
  assign ex = chain[MAX_BLOCKS];

  always_comb begin
    pend_d            = '0;
    sum_d             = sum_q;
    if (ex.status != ST_OK) begin
      pend_d.status = ex.status;
    end else if (!ex.found) begin
      pend_d.status = ST_NO_BLOCK;
    end else if (ex.opcode == OP_ALLOC) begin
      pend_d.status     = ST_OK;
      pend_d.out_block  = ex.hit;
      pend_d.out_offset = ex.hit_ofs;
      sum_d             = sum_q + SUM_W'(ex.chunk);
    end else begin
      pend_d.status = ST_OK;
      sum_d         = sum_q - SUM_W'(ex.dec);
    end
    pend_d.total_used = sum_d;
  end

  // Advance totals, result stage, output register and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q     <= '0;
      sum_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      busy_q     <= 1'b0;
    end else begin
      if (ex.valid) begin
        sum_q      <= sum_d;
        pend_vld_q <= 1'b1;
        if (ex.opened) begin
          open_q <= open_q + CNT_W'(1);
        end
      end else if (pend_vld_q && out_free) begin
        pend_vld_q <= 1'b0;
      end
      if (pend_vld_q && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_free) begin
        out_vld_q <= 1'b0;
      end
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (pend_vld_q && out_free) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex.valid) begin
      pend_q <= pend_d;
    end
    if (pend_vld_q && out_free) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `include "block_bump_allocator_unit_assert.svh"

  `BBA_ASSERT(a_one_beat_in_row, $countones(chain_vld) <= 1, "more than one request in the row")
  `BBA_ASSERT(a_open_bound, 32'(open_q) <= MAX_BLOCKS, "open block count past block row")
  `BBA_ASSERT(a_busy_after_accept, in_acc |=> busy_q, "request taken without busy flag")
  `BBA_ASSERT_ALWAYS(a_idle_row_empty, !busy_q |-> (chain_vld == '0), "row busy while idle")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the first-fit multi-block bump allocator.
module tb_top;
  import bba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned         N_BLOCKS    = BBA_MAX_BLOCKS;
  localparam longint unsigned     BLK_BYTES   = BBA_BLOCK_BYTES;
  localparam longint unsigned     ALIGN       = BBA_CHUNK_ALIGN;
  localparam int unsigned         LATENCY     = BBA_MAX_BLOCKS + 3;
  localparam int unsigned         WATCHDOG    = 4000;
  localparam int unsigned         PHASE_ITEMS = 300;
  localparam int unsigned         N_PHASES    = 6;
  localparam logic [CFG_W-1:0]    LIMIT_SET [N_PHASES] = '{5'd1, 5'd4, 5'd0, 5'd31, 5'd16, 5'd17};
  localparam logic                HUGE_SET  [N_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  // A chunk handed out and not yet released, kept to build well-formed frees.
  typedef struct {
    logic [BLK_W-1:0]  blk;
    logic [OFS_W-1:0]  ofs;
    logic [SIZE_W-1:0] size;
  } chunk_rec_t;

  logic             clk_i;
  logic             rst_ni     = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  req_t             in_data_i  = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  rsp_t             out_data_o;
  logic             cfg_we_i   = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i  = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  // Allocator state as predicted.
  logic [OFS_W-1:0] bump_ofs [N_BLOCKS];
  logic [OFS_W-1:0] blk_used [N_BLOCKS];
  logic [LIM_W-1:0] n_open     = '0;
  logic [SUM_W-1:0] used_total = '0;
  logic [CFG_W-1:0] lim_cfg    = '0;
  logic             huge_ok    = 1'b1;

  req_t       pending_req_q [$];
  rsp_t       want_rsp_q    [$];
  chunk_rec_t live_chunks   [$];

  int unsigned n_queued, n_taken, n_done, n_fail, n_settings;
  int unsigned n_placed, n_freed, n_refused, n_oversize;
  int unsigned req_gap, rsp_hold, quiet_cycles;
  bit          in_calm, out_calm;

  block_bump_allocator_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    foreach (bump_ofs[b]) begin
      bump_ofs[b] = '0;
      blk_used[b] = '0;
    end
  end

  // Apply one request to the predicted state and return the response it gives.
  function automatic rsp_t place_or_release(req_t r);
    rsp_t            res;
    longint unsigned size, chunk, dec, cur;
    int unsigned     lim, hit, i, f;
    int              k;
    bit              found;
    res        = '0;
    res.status = ST_OK;
    size       = r.req_size;
    chunk      = ((size + ALIGN - 1) / ALIGN) * ALIGN;
    if (size > BLK_BYTES) begin
      res.status = huge_ok ? ST_HUGE : ST_HUGE_ERR;
      n_oversize++;
    end else if (r.opcode == OP_ALLOC) begin
      found = 1'b0;
      hit   = 0;
      // first fit over the open blocks
      for (i = 0; i < n_open; i++) begin
        cur = bump_ofs[i];
        if (!found && cur + size <= BLK_BYTES) begin
          hit   = i;
          found = 1'b1;
        end
      end
      // open a new block unless the limit is reached
      if (!found) begin
        lim = (lim_cfg == 0 || lim_cfg > N_BLOCKS) ? N_BLOCKS : lim_cfg;
        if (n_open >= lim) begin
          res.status = ST_NO_BLOCK;
          n_refused++;
        end else begin
          hit           = n_open;
          bump_ofs[hit] = '0;
          blk_used[hit] = '0;
          n_open++;
          found = 1'b1;
        end
      end
      if (found) begin
        res.out_block  = BLK_W'(hit);
        res.out_offset = bump_ofs[hit];
        bump_ofs[hit]  = OFS_W'(bump_ofs[hit] + chunk);
        blk_used[hit]  = OFS_W'(blk_used[hit] + chunk);
        used_total     = SUM_W'(used_total + chunk);
        live_chunks.push_back('{blk: BLK_W'(hit), ofs: res.out_offset, size: r.req_size});
        n_placed++;
      end
    end else if (r.free_block >= n_open) begin
      res.status = ST_NO_BLOCK;
      n_refused++;
    end else begin
      f   = r.free_block;
      dec = chunk;
      if (dec > blk_used[f]) dec = blk_used[f];
      blk_used[f] = OFS_W'(blk_used[f] - dec);
      // roll back the last chunk placed
      cur = bump_ofs[f];
      if (cur == r.free_offset + chunk) bump_ofs[f] = OFS_W'(cur - chunk);
      // rewind an empty block and forget its chunks
      if (blk_used[f] == '0) begin
        bump_ofs[f] = '0;
        for (k = live_chunks.size() - 1; k >= 0; k--) begin
          if (live_chunks[k].blk == f) live_chunks.delete(k);
        end
      end
      used_total = SUM_W'(used_total - dec);
      n_freed++;
    end
    res.total_used = used_total;
    return res;
  endfunction

  function automatic void queue_req(logic op, logic [SIZE_W-1:0] sz, logic [BLK_W-1:0] blk,
                                    logic [OFS_W-1:0] ofs);
    req_t r;
    r.opcode      = op;
    r.req_size    = sz;
    r.free_block  = blk;
    r.free_offset = ofs;
    pending_req_q.push_back(r);
    n_queued++;
  endfunction

  // Mix of tiny, medium, large and block-sized requests.
  function automatic logic [SIZE_W-1:0] draw_size();
    logic [SIZE_W-1:0] sz;
    case ($urandom_range(9, 0))
      0:       sz = SIZE_W'($urandom_range(64, 0));
      1, 2, 3: sz = SIZE_W'($urandom_range(65536, 1));
      4, 5:    sz = SIZE_W'($urandom_range(1 << 22, 65537));
      6, 7:    sz = SIZE_W'($urandom_range(BBA_BLOCK_BYTES, 1 << 22));
      default: begin
        case ($urandom_range(3, 0))
          0:       sz = SIZE_W'(BLK_BYTES);
          1:       sz = SIZE_W'(BLK_BYTES - 1);
          2:       sz = SIZE_W'(BLK_BYTES - 15);
          default: sz = SIZE_W'(16);
        endcase
      end
    endcase
    return sz;
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_BLOCK_LIMIT) lim_cfg = val;
    else huge_ok = val[0];
  endtask

  // Wait until every queued request has its response, then let the pipe drain.
  task automatic settle();
    wait (n_taken == n_queued && n_done == n_queued);
    repeat (2 * LATENCY) @(posedge clk_i);
  endtask

  task automatic set_mode(logic [CFG_W-1:0] lim, logic huge);
    settle();
    write_reg(REG_BLOCK_LIMIT, lim);
    write_reg(REG_ALLOW_HUGE, CFG_W'(huge));
    n_settings++;
  endtask

  // Stimulus: directed corner cases, then random phases under each setting.
  initial begin
    int unsigned made, burst, roll, pick, j, ph;
    chunk_rec_t  c;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // two blocks at most, oversize reported as huge
    set_mode(CFG_W'(2), 1'b1);
    queue_req(OP_ALLOC, 32'd0, '0, '0);
    queue_req(OP_ALLOC, 32'd1, '1, '1);
    queue_req(OP_ALLOC, 32'd16, '0, '0);
    queue_req(OP_ALLOC, 32'd17, '0, '0);
    queue_req(OP_ALLOC, SIZE_W'(BLK_BYTES), '0, '0);
    queue_req(OP_ALLOC, SIZE_W'(BLK_BYTES + 1), '0, '0);
    queue_req(OP_ALLOC, 32'hFFFF_FFFF, '0, '0);
    queue_req(OP_ALLOC, 32'd100, '0, '0);
    queue_req(OP_ALLOC, SIZE_W'(BLK_BYTES - 15), '0, '0);
    queue_req(OP_FREE, 32'd16, BLK_W'(2), '0);
    queue_req(OP_FREE, 32'd1, '1, '1);
    queue_req(OP_FREE, SIZE_W'(BLK_BYTES + 1), '0, '0);
    // release the last chunk, then one in the middle
    queue_req(OP_FREE, 32'd100, BLK_W'(0), OFS_W'(64));
    queue_req(OP_FREE, 32'd16, BLK_W'(0), OFS_W'(16));
    // empty a block, free from an empty block, over-free another
    queue_req(OP_FREE, SIZE_W'(BLK_BYTES), BLK_W'(1), '0);
    queue_req(OP_FREE, 32'd4096, BLK_W'(1), '0);
    queue_req(OP_FREE, 32'd4096, BLK_W'(0), '0);
    queue_req(OP_ALLOC, SIZE_W'(BLK_BYTES), '0, '0);

    // no block limit, oversize is an error
    set_mode(CFG_W'(0), 1'b0);
    queue_req(OP_ALLOC, SIZE_W'(BLK_BYTES + 1), '0, '0);
    queue_req(OP_FREE, 32'hFFFF_FFFF, '0, '0);
    queue_req(OP_ALLOC, SIZE_W'(BLK_BYTES - 15), '0, '0);
    queue_req(OP_ALLOC, 32'd1, '0, '0);

    for (ph = 0; ph < N_PHASES; ph++) begin
      set_mode(LIMIT_SET[ph], HUGE_SET[ph]);
      made = 0;
      while (made < PHASE_ITEMS) begin
        burst = $urandom_range(8, 1);
        for (j = 0; j < burst; j++) begin
          roll = $urandom_range(99, 0);
          if (roll < 8) begin
            // noise: any opcode, any size, any block and offset
            queue_req(logic'($urandom_range(1, 0)),
                      $urandom_range(1, 0) ? SIZE_W'($urandom()) : draw_size(),
                      BLK_W'($urandom()), OFS_W'($urandom()));
          end else if (live_chunks.size() > 0 && (roll < 50 || live_chunks.size() > 24)) begin
            // release a live chunk, often the newest one
            pick = $urandom_range(1, 0) ? live_chunks.size() - 1
                                        : $urandom_range(live_chunks.size() - 1, 0);
            c = live_chunks[pick];
            live_chunks.delete(pick);
            queue_req(OP_FREE, c.size, c.blk, c.ofs);
          end else begin
            queue_req(OP_ALLOC, draw_size(), BLK_W'($urandom()), OFS_W'($urandom()));
          end
        end
        made += burst;
        wait (n_taken == n_queued);
      end
    end

    settle();
    $display("Checked %0d response beats over %0d register settings.", n_done, n_settings);
    $display("Placed %0d chunks, released %0d, refused %0d, %0d oversize; %0d blocks open.",
             n_placed, n_freed, n_refused, n_oversize, n_open);
    if (n_fail == 0) begin
      $display("PASS block_bump_allocator_unit");
    end else begin
      $display("FAIL block_bump_allocator_unit");
    end
    $finish;
  end

  // Request driver: predict on every accepted beat, then load the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want_rsp_q.push_back(place_or_release(in_data_i));
        n_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (req_gap > 0) begin
          req_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_req_q.size() > 0) begin
          in_data_i  <= pending_req_q.pop_front();
          in_valid_i <= 1'b1;
          if ($urandom_range(29, 0) == 0) in_calm = !in_calm;
          req_gap = in_calm ? 0 : $urandom_range(14, 0);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Response monitor: compare each beat with the oldest expectation, stall at random.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (want_rsp_q.size() == 0) begin
          $error("response beat with no request outstanding");
          n_fail++;
        end else begin
          want = want_rsp_q.pop_front();
          n_done++;
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_o.status);
            n_fail++;
          end
          if (out_data_o.out_block !== want.out_block) begin
            $error("out_block: expected %0d, got %0d", want.out_block, out_data_o.out_block);
            n_fail++;
          end
          if (out_data_o.out_offset !== want.out_offset) begin
            $error("out_offset: expected %0d, got %0d", want.out_offset, out_data_o.out_offset);
            n_fail++;
          end
          if (out_data_o.total_used !== want.total_used) begin
            $error("total_used: expected %0d, got %0d", want.total_used, out_data_o.total_used);
            n_fail++;
          end
        end
        if ($urandom_range(29, 0) == 0) out_calm = !out_calm;
        rsp_hold = out_calm ? 0 : $urandom_range(14, 0);
      end
      if (rsp_hold > 0) begin
        out_stall_i <= 1'b1;
        rsp_hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG) begin
        $display("Timeout: %0d cycles without a beat.", quiet_cycles);
        $display("FAIL block_bump_allocator_unit");
        $finish;
      end
    end
  end

endmodule
